[rtl/sms_pkg.sv]
// Package with the word types, codes and timing constants of the stepper motion sequencer.
package sms_pkg;

   localparam int POSITION_WIDTH = 32;
   localparam int DELAY_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic signed [31:0] SOFT_MIN_RESET = 32'sh8000_0000;
   localparam logic signed [31:0] SOFT_MAX_RESET = 32'sh7FFF_FFFF;
   localparam logic [DELAY_WIDTH-1:0] INTERVAL_RESET = 16'd1000;

   localparam logic [31:0] SEEK_TIMEOUT_MS = 32'd30000;
   localparam logic [31:0] BACKOFF_TIMEOUT_MS = 32'd1000;
   localparam logic [DELAY_WIDTH-1:0] SETTLE_US = 16'd10000;
   localparam logic [DELAY_WIDTH-1:0] STOP_US = 16'd5000;
   localparam logic [DELAY_WIDTH-1:0] RELEASE_US = 16'd100;
   localparam logic [DELAY_WIDTH-1:0] QUICK_US = 16'd10;

   typedef enum logic [2:0] {
      ACT_TICK = 3'd0,
      ACT_GOTO = 3'd1,
      ACT_MOVE = 3'd2,
      ACT_CONT = 3'd3,
      ACT_HOME = 3'd4,
      ACT_STOP = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      MODE_OFF  = 3'd0,
      MODE_POS  = 3'd1,
      MODE_INC  = 3'd2,
      MODE_CONT = 3'd3,
      MODE_HOME = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SOFT_MIN      = 2'd0,
      CSR_SOFT_MAX      = 2'd1,
      CSR_STEP_INTERVAL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] target;
      logic               run_direction;
      logic               hard_limit;
      logic [31:0]        now_ms;
   } req_word_type;

   typedef struct packed {
      logic                   step_pulse;
      logic                   step_direction;
      logic                   coils_on;
      logic                   timer_armed;
      logic [DELAY_WIDTH-1:0] next_delay_us;
      logic signed [31:0]     position;
      logic                   homed;
      logic                   busy_res;
   } rsp_word_type;

endpackage

[rtl/stepper_motion_sequencer.sv]
// Stepper motion sequencer top level: command and tick handling for one stepper axis.

// Every request word (a command or a timer tick) yields exactly one response word that
// reports the axis after that word. A request word is held in an input register and
// processed once the response register is free or being read; then the axis state and
// the response register are updated together. One word per cycle is sustained while
// rsp_ready stays high; the rate is set by the state update that each word performs
// before the next one may use it. The output register lets a new word be taken
// while a response still waits. Register writes are always accepted (csr_ready is high)
// and take effect at once; they are meant to be issued only while no word is in flight.
// POSITION_WIDTH (16 to 32) sets the width of the position and goal counters, which wrap.
module stepper_motion_sequencer #(
   parameter int POSITION_WIDTH = sms_pkg::POSITION_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sms_pkg::req_word_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sms_pkg::rsp_word_type                 rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sms_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sms_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int PW = POSITION_WIDTH;
   localparam int DW = sms_pkg::DELAY_WIDTH;

   logic                  in_vld_ff;
   sms_pkg::req_word_type in_ff;
   logic                  rsp_vld_ff;
   sms_pkg::rsp_word_type rsp_ff;
   sms_pkg::rsp_word_type rsp_in;
   logic                  req_take;
   logic                  load_rsp;

   logic signed [31:0] soft_min_ff;
   logic signed [31:0] soft_max_ff;
   logic [DW-1:0]      interval_ff;

   logic signed [PW-1:0] pos_ff, pos_in;
   logic signed [PW-1:0] goal_ff, goal_in;
   logic [31:0]          steps_left_ff, steps_left_in;
   logic                 dir_ff, dir_in;
   sms_pkg::mode_type    mode_ff, mode_in;
   logic                 phase_ff, phase_in;
   logic                 homed_ff, homed_in;
   logic                 running_ff, running_in;
   logic [31:0]          phase_start_ff, phase_start_in;
   logic                 coil_ff, coil_in;
   logic                 armed_ff, armed_in;
   logic [DW-1:0]        delay_ff, delay_in;
   logic                 step_c;

   logic signed [31:0]   pos_ext;
   logic signed [PW-1:0] pos_up;
   logic signed [PW-1:0] pos_dn;
   logic signed [PW-1:0] target_wrap;
   logic                 blocked;
   logic [31:0]          elapsed;
   logic [DW:0]          interval_dbl;
   logic [DW-1:0]        backoff_delay;
   logic [31:0]          target_abs;
   logic signed [PW-1:0] pos_toward_goal;
   logic                 goto_reject;

   assign req_take  = req_valid && req_ready;
   assign load_rsp  = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || load_rsp;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_take) begin
         in_vld_ff <= 1'b1;
      end else if (load_rsp) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_min_ff <= sms_pkg::SOFT_MIN_RESET;
         soft_max_ff <= sms_pkg::SOFT_MAX_RESET;
         interval_ff <= sms_pkg::INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (sms_pkg::csr_index_type'(csr_index))
            sms_pkg::CSR_SOFT_MIN: begin
               soft_min_ff <= signed'(csr_wdata);
            end
            sms_pkg::CSR_SOFT_MAX: begin
               soft_max_ff <= signed'(csr_wdata);
            end
            sms_pkg::CSR_STEP_INTERVAL: begin
               interval_ff <= csr_wdata[DW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign pos_ext         = 32'(pos_ff);
   assign pos_up          = pos_ff + PW'(1);
   assign pos_dn          = pos_ff - PW'(1);
   assign target_wrap     = signed'(in_ff.target[PW-1:0]);
   assign blocked         = (!dir_ff && (in_ff.hard_limit || (pos_ext <= soft_min_ff))) ||
                            (dir_ff && (pos_ext >= soft_max_ff));
   assign elapsed         = in_ff.now_ms - phase_start_ff;
   assign interval_dbl    = {interval_ff, 1'b0};
   assign backoff_delay   = interval_dbl[DW] ? '1 : interval_dbl[DW-1:0];
   assign target_abs      = in_ff.target[31] ? (~in_ff.target + 32'd1) : in_ff.target;
   assign pos_toward_goal = (goal_ff > pos_ff) ? pos_up : pos_dn;
   assign goto_reject     = (in_ff.target > soft_max_ff) || (in_ff.target < soft_min_ff) ||
                            (in_ff.target == pos_ext);

   always_comb begin
      pos_in         = pos_ff;
      goal_in        = goal_ff;
      steps_left_in  = steps_left_ff;
      dir_in         = dir_ff;
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      homed_in       = homed_ff;
      running_in     = running_ff;
      phase_start_in = phase_start_ff;
      coil_in        = coil_ff;
      armed_in       = armed_ff;
      delay_in       = delay_ff;
      step_c         = 1'b0;
      case (sms_pkg::action_type'(in_ff.action))
         sms_pkg::ACT_TICK: begin
            case (mode_ff)
               sms_pkg::MODE_HOME: begin
                  if (!phase_ff) begin
                     if (in_ff.hard_limit) begin
                        dir_in         = !dir_ff;
                        phase_start_in = in_ff.now_ms;
                        phase_in       = 1'b1;
                        armed_in       = 1'b1;
                        delay_in       = sms_pkg::RELEASE_US;
                     end else if (elapsed >= sms_pkg::SEEK_TIMEOUT_MS) begin
                        mode_in    = sms_pkg::MODE_OFF;
                        running_in = 1'b1;
                        armed_in   = 1'b1;
                        delay_in   = sms_pkg::STOP_US;
                     end else begin
                        pos_in   = dir_ff ? pos_up : pos_dn;
                        step_c   = 1'b1;
                        armed_in = 1'b1;
                        delay_in = interval_ff;
                     end
                  end else begin
                     if (!in_ff.hard_limit) begin
                        homed_in = 1'b1;
                        pos_in   = '0;
                        phase_in = 1'b0;
                        mode_in  = sms_pkg::MODE_OFF;
                        armed_in = 1'b1;
                        delay_in = sms_pkg::SETTLE_US;
                     end else if (elapsed >= sms_pkg::BACKOFF_TIMEOUT_MS) begin
                        mode_in  = sms_pkg::MODE_OFF;
                        armed_in = 1'b1;
                        delay_in = sms_pkg::SETTLE_US;
                     end else begin
                        pos_in   = dir_ff ? pos_up : pos_dn;
                        step_c   = 1'b1;
                        armed_in = 1'b1;
                        delay_in = backoff_delay;
                     end
                  end
               end
               sms_pkg::MODE_INC: begin
                  mode_in  = sms_pkg::MODE_OFF;
                  armed_in = 1'b1;
                  delay_in = sms_pkg::QUICK_US;
                  if (homed_ff && blocked) begin
                     delay_in = sms_pkg::SETTLE_US;
                  end else if (homed_ff && (steps_left_ff != '0)) begin
                     pos_in        = dir_ff ? pos_up : pos_dn;
                     step_c        = 1'b1;
                     steps_left_in = steps_left_ff - 32'd1;
                     if (steps_left_ff == 32'd1) begin
                        delay_in = sms_pkg::SETTLE_US;
                     end else begin
                        mode_in  = sms_pkg::MODE_INC;
                        delay_in = interval_ff;
                     end
                  end
               end
               sms_pkg::MODE_CONT: begin
                  armed_in = 1'b1;
                  if (!homed_ff) begin
                     mode_in  = sms_pkg::MODE_OFF;
                     delay_in = sms_pkg::QUICK_US;
                  end else if (blocked) begin
                     mode_in  = sms_pkg::MODE_OFF;
                     delay_in = sms_pkg::SETTLE_US;
                  end else begin
                     pos_in   = dir_ff ? pos_up : pos_dn;
                     step_c   = 1'b1;
                     delay_in = interval_ff;
                  end
               end
               sms_pkg::MODE_POS: begin
                  armed_in = 1'b1;
                  mode_in  = sms_pkg::MODE_OFF;
                  delay_in = sms_pkg::SETTLE_US;
                  if (!homed_ff) begin
                     delay_in = sms_pkg::QUICK_US;
                  end else if (!blocked && (goal_ff != pos_ff)) begin
                     dir_in = goal_ff > pos_ff;
                     pos_in = pos_toward_goal;
                     step_c = 1'b1;
                     if (goal_ff != pos_toward_goal) begin
                        mode_in  = sms_pkg::MODE_POS;
                        delay_in = interval_ff;
                     end
                  end
               end
               sms_pkg::MODE_OFF: begin
                  coil_in    = 1'b0;
                  armed_in   = 1'b0;
                  running_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         sms_pkg::ACT_GOTO: begin
            if (!goto_reject) begin
               mode_in    = sms_pkg::MODE_POS;
               goal_in    = target_wrap;
               dir_in     = target_wrap > pos_ff;
               coil_in    = 1'b1;
               running_in = 1'b1;
               armed_in   = 1'b1;
               delay_in   = running_ff ? interval_ff : sms_pkg::SETTLE_US;
            end
         end
         sms_pkg::ACT_MOVE: begin
            if (in_ff.target != '0) begin
               dir_in        = !in_ff.target[31];
               steps_left_in = target_abs;
               coil_in       = 1'b1;
               mode_in       = sms_pkg::MODE_INC;
               armed_in      = 1'b1;
               delay_in      = running_ff ? interval_ff : sms_pkg::SETTLE_US;
               running_in    = 1'b1;
            end
         end
         sms_pkg::ACT_CONT: begin
            dir_in     = in_ff.run_direction;
            mode_in    = sms_pkg::MODE_CONT;
            running_in = 1'b1;
            coil_in    = 1'b1;
            armed_in   = 1'b1;
            delay_in   = sms_pkg::SETTLE_US;
         end
         sms_pkg::ACT_HOME: begin
            coil_in        = 1'b1;
            mode_in        = sms_pkg::MODE_HOME;
            phase_in       = 1'b0;
            running_in     = 1'b1;
            homed_in       = 1'b0;
            dir_in         = 1'b0;
            phase_start_in = in_ff.now_ms;
            armed_in       = 1'b1;
            delay_in       = sms_pkg::SETTLE_US;
         end
         sms_pkg::ACT_STOP: begin
            mode_in    = sms_pkg::MODE_OFF;
            running_in = 1'b1;
            armed_in   = 1'b1;
            delay_in   = sms_pkg::STOP_US;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.step_pulse     = step_c;
      rsp_in.step_direction = dir_in;
      rsp_in.coils_on       = coil_in;
      rsp_in.timer_armed    = armed_in;
      rsp_in.next_delay_us  = armed_in ? delay_in : '0;
      rsp_in.position       = 32'(pos_in);
      rsp_in.homed          = homed_in;
      rsp_in.busy_res       = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         goal_ff        <= '0;
         steps_left_ff  <= '0;
         dir_ff         <= 1'b0;
         mode_ff        <= sms_pkg::MODE_OFF;
         phase_ff       <= 1'b0;
         homed_ff       <= 1'b0;
         running_ff     <= 1'b0;
         phase_start_ff <= '0;
         coil_ff        <= 1'b0;
         armed_ff       <= 1'b0;
         delay_ff       <= '0;
      end else if (load_rsp) begin
         pos_ff         <= pos_in;
         goal_ff        <= goal_in;
         steps_left_ff  <= steps_left_in;
         dir_ff         <= dir_in;
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         homed_ff       <= homed_in;
         running_ff     <= running_in;
         phase_start_ff <= phase_start_in;
         coil_ff        <= coil_in;
         armed_ff       <= armed_in;
         delay_ff       <= delay_in;
      end
   end

   a_step_moves_one: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && step_c) |=>
         (dir_ff ? (pos_ff == $past(pos_ff) + PW'(1)) : (pos_ff == $past(pos_ff) - PW'(1))))
      else $error("A step did not move the position by one toward the direction.");

   a_position_holds: assert property (@(posedge clock) disable iff (reset)
      !(load_rsp && step_c) |=> ($stable(pos_ff) || $rose(homed_ff)))
      else $error("The position changed without a step or a homing completion.");

   a_homed_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(homed_ff) |-> (pos_ff == '0))
      else $error("Homing completed with a nonzero position.");

   a_step_energized: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.step_pulse) |->
         (rsp_ff.coils_on && rsp_ff.busy_res && rsp_ff.timer_armed))
      else $error("A step was reported with coils off, axis idle or timer disarmed.");

   a_delay_when_disarmed: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.timer_armed) |-> (rsp_ff.next_delay_us == '0))
      else $error("A delay was reported while the timer is disarmed.");

endmodule

[dv/tb_top.sv]
// Self-checking testbench of the stepper motion sequencer with its own axis predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD_CYCLES = 90;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sms_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sms_pkg::rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sms_pkg::CSR_INDEX_WIDTH-1:0] csr_index = sms_pkg::CSR_SOFT_MIN;
   logic [sms_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   logic signed [31:0] soft_min_m = sms_pkg::SOFT_MIN_RESET;
   logic signed [31:0] soft_max_m = sms_pkg::SOFT_MAX_RESET;
   logic [15:0] interval_m = sms_pkg::INTERVAL_RESET;

   logic signed [31:0] ax_pos = '0;
   logic signed [31:0] ax_goal = '0;
   logic [31:0] ax_steps = '0;
   logic ax_dir = 1'b0;
   sms_pkg::mode_type ax_mode = sms_pkg::MODE_OFF;
   logic ax_hphase = 1'b0;
   logic ax_homed = 1'b0;
   logic ax_running = 1'b0;
   logic [31:0] ax_phase_ms = '0;
   logic ax_coils = 1'b0;
   logic ax_armed = 1'b0;
   logic [15:0] ax_delay = '0;

   sms_pkg::rsp_word_type axis_status_q[$];
   logic [31:0] clock_ms = '0;
   int items_sent = 0;
   int fail_count = 0;
   int cycle_count = 0;
   logic idle_enable = 1'b1;
   logic long_hold_pending = 1'b0;

   stepper_motion_sequencer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void arm_tick(input logic [31:0] us);
      ax_delay = (us > 32'd65535) ? 16'hFFFF : us[15:0];
      ax_armed = 1'b1;
   endfunction

   function automatic void take_step();
      ax_pos = ax_dir ? ax_pos + 32'sd1 : ax_pos - 32'sd1;
   endfunction

   function automatic void end_motion(input logic [31:0] us);
      ax_mode = sms_pkg::MODE_OFF;
      arm_tick(us);
   endfunction

   function automatic sms_pkg::rsp_word_type advance_axis(input sms_pkg::req_word_type w);
      sms_pkg::rsp_word_type r;
      logic stepped;
      logic at_min;
      logic at_max;
      logic blocked;
      logic [31:0] elapsed;
      logic signed [31:0] tgt;
      stepped = 1'b0;
      tgt = w.target;
      case (w.action)
         sms_pkg::ACT_TICK: begin
            at_min = ax_pos <= soft_min_m;
            at_max = ax_pos >= soft_max_m;
            blocked = (w.hard_limit && !ax_dir) || (at_min && !ax_dir) || (at_max && ax_dir);
            elapsed = w.now_ms - ax_phase_ms;
            case (ax_mode)
               sms_pkg::MODE_HOME: begin
                  if (!ax_hphase) begin
                     if (w.hard_limit) begin
                        ax_dir = ~ax_dir;
                        ax_phase_ms = w.now_ms;
                        ax_hphase = 1'b1;
                        arm_tick(32'(sms_pkg::RELEASE_US));
                     end else if (elapsed >= sms_pkg::SEEK_TIMEOUT_MS) begin
                        ax_mode = sms_pkg::MODE_OFF;
                        ax_running = 1'b1;
                        arm_tick(32'(sms_pkg::STOP_US));
                     end else begin
                        take_step();
                        stepped = 1'b1;
                        arm_tick(32'(interval_m));
                     end
                  end else begin
                     if (!w.hard_limit) begin
                        ax_homed = 1'b1;
                        ax_pos = '0;
                        ax_hphase = 1'b0;
                        end_motion(32'(sms_pkg::SETTLE_US));
                     end else if (elapsed >= sms_pkg::BACKOFF_TIMEOUT_MS) begin
                        end_motion(32'(sms_pkg::SETTLE_US));
                     end else begin
                        take_step();
                        stepped = 1'b1;
                        arm_tick({15'd0, interval_m, 1'b0});
                     end
                  end
               end
               sms_pkg::MODE_INC: begin
                  if (!ax_homed) begin
                     end_motion(32'(sms_pkg::QUICK_US));
                  end else if (blocked) begin
                     end_motion(32'(sms_pkg::SETTLE_US));
                  end else if (ax_steps != 32'd0) begin
                     take_step();
                     stepped = 1'b1;
                     ax_steps = ax_steps - 32'd1;
                     if (ax_steps == 32'd0) end_motion(32'(sms_pkg::SETTLE_US));
                     else arm_tick(32'(interval_m));
                  end else begin
                     end_motion(32'(sms_pkg::QUICK_US));
                  end
               end
               sms_pkg::MODE_CONT: begin
                  if (!ax_homed) begin
                     end_motion(32'(sms_pkg::QUICK_US));
                  end else if (blocked) begin
                     end_motion(32'(sms_pkg::SETTLE_US));
                  end else begin
                     take_step();
                     stepped = 1'b1;
                     arm_tick(32'(interval_m));
                  end
               end
               sms_pkg::MODE_POS: begin
                  if (!ax_homed) begin
                     end_motion(32'(sms_pkg::QUICK_US));
                  end else if (blocked) begin
                     end_motion(32'(sms_pkg::SETTLE_US));
                  end else if (ax_goal != ax_pos) begin
                     ax_dir = ax_goal > ax_pos;
                     take_step();
                     stepped = 1'b1;
                     if (ax_goal == ax_pos) end_motion(32'(sms_pkg::SETTLE_US));
                     else arm_tick(32'(interval_m));
                  end else begin
                     end_motion(32'(sms_pkg::SETTLE_US));
                  end
               end
               sms_pkg::MODE_OFF: begin
                  ax_coils = 1'b0;
                  ax_armed = 1'b0;
                  ax_running = 1'b0;
               end
               default: ;
            endcase
         end
         sms_pkg::ACT_GOTO: begin
            if (!(tgt > soft_max_m || tgt < soft_min_m || tgt == ax_pos)) begin
               ax_mode = sms_pkg::MODE_POS;
               ax_goal = tgt;
               ax_dir = ax_goal > ax_pos;
               ax_coils = 1'b1;
               if (ax_running) begin
                  arm_tick(32'(interval_m));
               end else begin
                  ax_running = 1'b1;
                  arm_tick(32'(sms_pkg::SETTLE_US));
               end
            end
         end
         sms_pkg::ACT_MOVE: begin
            if (tgt != 32'sd0) begin
               ax_dir = tgt > 32'sd0;
               ax_steps = (tgt < 32'sd0) ? -tgt : tgt;
               ax_coils = 1'b1;
               ax_mode = sms_pkg::MODE_INC;
               arm_tick(ax_running ? {16'd0, interval_m} : {16'd0, sms_pkg::SETTLE_US});
               ax_running = 1'b1;
            end
         end
         sms_pkg::ACT_CONT: begin
            ax_dir = w.run_direction;
            ax_mode = sms_pkg::MODE_CONT;
            ax_running = 1'b1;
            ax_coils = 1'b1;
            arm_tick(32'(sms_pkg::SETTLE_US));
         end
         sms_pkg::ACT_HOME: begin
            ax_coils = 1'b1;
            ax_mode = sms_pkg::MODE_HOME;
            ax_hphase = 1'b0;
            ax_running = 1'b1;
            ax_homed = 1'b0;
            ax_dir = 1'b0;
            ax_phase_ms = w.now_ms;
            arm_tick(32'(sms_pkg::SETTLE_US));
         end
         sms_pkg::ACT_STOP: begin
            ax_mode = sms_pkg::MODE_OFF;
            ax_running = 1'b1;
            arm_tick(32'(sms_pkg::STOP_US));
         end
         default: ;
      endcase
      r.step_pulse = stepped;
      r.step_direction = ax_dir;
      r.coils_on = ax_coils;
      r.timer_armed = ax_armed;
      r.next_delay_us = ax_armed ? ax_delay : '0;
      r.position = ax_pos;
      r.homed = ax_homed;
      r.busy_res = ax_running;
      return r;
   endfunction

   function automatic sms_pkg::req_word_type req_word(input logic [2:0] act,
                                                      input logic [31:0] tgt,
                                                      input logic dir, input logic hard,
                                                      input logic [31:0] now);
      sms_pkg::req_word_type w;
      w.action = act;
      w.target = tgt;
      w.run_direction = dir;
      w.hard_limit = hard;
      w.now_ms = now;
      return w;
   endfunction

   // Entered and left at a falling edge; valid stays high on return until the next call or a register write.
   task automatic send_word(input sms_pkg::req_word_type w);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      axis_status_q.push_back(advance_axis(w));
      if (w.action <= sms_pkg::ACT_STOP) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_cmd(input logic [2:0] act, input logic [31:0] tgt, input logic dir);
      send_word(req_word(act, tgt, dir, 1'($urandom_range(0, 1)), clock_ms));
   endtask

   task automatic send_tick(input logic hard, input logic [31:0] advance_ms);
      clock_ms = clock_ms + advance_ms;
      send_word(req_word(sms_pkg::ACT_TICK, $urandom, 1'($urandom_range(0, 1)), hard,
                         clock_ms));
   endtask

   task automatic write_csr(input logic [sms_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [31:0] value);
      req_valid <= 1'b0;
      while (axis_status_q.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sms_pkg::CSR_SOFT_MIN: soft_min_m = value;
         sms_pkg::CSR_SOFT_MAX: soft_max_m = value;
         sms_pkg::CSR_STEP_INTERVAL: interval_m = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_homing();
      send_cmd(sms_pkg::ACT_HOME, $urandom, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 8)) send_tick(1'b0, $urandom_range(0, 30));
      if ($urandom_range(0, 9) == 0) begin
         send_tick(1'b0, sms_pkg::SEEK_TIMEOUT_MS + $urandom_range(0, 500));
      end else begin
         send_tick(1'b1, $urandom_range(0, 30));
         repeat ($urandom_range(0, 4)) send_tick(1'b1, $urandom_range(0, 30));
         if ($urandom_range(0, 9) == 0) send_tick(1'b1, sms_pkg::BACKOFF_TIMEOUT_MS);
         send_tick(1'b0, $urandom_range(0, 30));
      end
      send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 30));
   endtask

   task automatic run_motion();
      int offset;
      int n;
      int tick_cap;
      logic signed [31:0] tgt;
      offset = int'($urandom_range(0, 120)) - 60;
      case ($urandom_range(0, 2))
         0: begin
            case ($urandom_range(0, 7))
               0: tgt = $urandom;
               1: tgt = soft_max_m;
               2: tgt = soft_min_m;
               default: tgt = ax_pos + offset;
            endcase
            send_cmd(sms_pkg::ACT_GOTO, tgt, 1'($urandom_range(0, 1)));
         end
         1: begin
            tgt = ($urandom_range(0, 9) == 0) ? $urandom : offset;
            send_cmd(sms_pkg::ACT_MOVE, tgt, 1'($urandom_range(0, 1)));
         end
         default: send_cmd(sms_pkg::ACT_CONT, $urandom, 1'($urandom_range(0, 1)));
      endcase
      n = 0;
      tick_cap = int'($urandom_range(1, 60));
      while (ax_mode != sms_pkg::MODE_OFF && n < tick_cap) begin
         if ($urandom_range(0, 29) == 0)
            send_cmd(sms_pkg::ACT_GOTO, ax_pos + $urandom_range(0, 20) - 10,
                     1'($urandom_range(0, 1)));
         send_tick($urandom_range(0, 11) == 0, $urandom_range(0, 30));
         n++;
      end
      if ($urandom_range(0, 4) != 0) begin
         if (ax_mode != sms_pkg::MODE_OFF)
            send_cmd(sms_pkg::ACT_STOP, $urandom, 1'($urandom_range(0, 1)));
         send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 30));
      end
   endtask

   task automatic run_random(input int count);
      int goal_items;
      goal_items = items_sent + count;
      while (items_sent < goal_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               repeat ($urandom_range(1, 3))
                  send_word(req_word(3'($urandom_range(0, 7)), $urandom,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     $urandom_range(0, 1) ? $urandom : clock_ms));
            end
            3: run_homing();
            default: begin
               if (!ax_homed) run_homing();
               else run_motion();
            end
         endcase
      end
   endtask

   task automatic test_directed();
      clock_ms = 32'hFFFF_FFFF;
      send_cmd(ACT_SPARE_LO, 32'h7FFF_FFFF, 1'b1);
      send_cmd(ACT_SPARE_HI, 32'h8000_0000, 1'b0);
      send_word(req_word(sms_pkg::ACT_TICK, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF));
      send_cmd(sms_pkg::ACT_GOTO, 32'd5, 1'b0);
      send_cmd(sms_pkg::ACT_GOTO, -32'sd7, 1'b0);
      send_tick(1'b0, 32'd1);
      send_tick(1'b0, 32'd1);
      send_cmd(sms_pkg::ACT_MOVE, 32'd0, 1'b0);
      send_cmd(sms_pkg::ACT_MOVE, 32'h8000_0000, 1'b0);
      send_tick(1'b0, 32'd1);
      send_cmd(sms_pkg::ACT_CONT, 32'h7FFF_FFFF, 1'b1);
      send_cmd(sms_pkg::ACT_STOP, 32'h0, 1'b0);
      send_tick(1'b0, 32'd1);
      // The seek phase times out across the wrap of the millisecond clock.
      clock_ms = 32'hFFFF_FF00;
      send_cmd(sms_pkg::ACT_HOME, 32'h0, 1'b0);
      send_tick(1'b0, 32'd29999);
      send_tick(1'b0, 32'd1);
      send_tick(1'b0, 32'd0);
      send_cmd(sms_pkg::ACT_HOME, 32'h0, 1'b1);
      send_tick(1'b0, 32'd5);
      send_tick(1'b1, 32'd5);
      send_tick(1'b1, 32'd5);
      send_tick(1'b1, sms_pkg::BACKOFF_TIMEOUT_MS);
      send_cmd(sms_pkg::ACT_HOME, 32'h0, 1'b0);
      send_tick(1'b1, 32'd3);
      send_tick(1'b0, 32'd3);
      send_cmd(sms_pkg::ACT_GOTO, 32'd0, 1'b0);
      send_cmd(sms_pkg::ACT_GOTO, 32'd2, 1'b0);
      repeat (3) send_tick(1'b0, 32'd2);
   endtask

   task automatic test_limit_sweep();
      write_csr(sms_pkg::CSR_SOFT_MIN, -32'sd30);
      write_csr(sms_pkg::CSR_SOFT_MAX, 32'sd30);
      write_csr(sms_pkg::CSR_STEP_INTERVAL, 32'd0);
      run_random(160);
      write_csr(sms_pkg::CSR_SOFT_MIN, 32'h8000_0000);
      write_csr(sms_pkg::CSR_SOFT_MAX, 32'h7FFF_FFFF);
      write_csr(sms_pkg::CSR_STEP_INTERVAL, 32'h0000_FFFF);
      run_random(160);
      idle_enable = 1'b0;
      write_csr(sms_pkg::CSR_SOFT_MIN, -32'sd5);
      write_csr(sms_pkg::CSR_SOFT_MAX, 32'sd200);
      write_csr(sms_pkg::CSR_STEP_INTERVAL, 32'd32768);
      run_random(160);
      idle_enable = 1'b1;
      write_csr(sms_pkg::CSR_SOFT_MIN, 32'sd10);
      write_csr(sms_pkg::CSR_SOFT_MAX, -32'sd10);
      write_csr(sms_pkg::CSR_STEP_INTERVAL, 32'd1000);
      run_random(80);
      write_csr(sms_pkg::CSR_SOFT_MIN, -$urandom_range(0, 80));
      write_csr(sms_pkg::CSR_SOFT_MAX, $urandom_range(0, 80));
      write_csr(sms_pkg::CSR_STEP_INTERVAL, $urandom_range(0, 65535));
      run_random(160);
   endtask

   task automatic test_backpressure();
      idle_enable = 1'b0;
      long_hold_pending = 1'b1;
      run_random(60);
      idle_enable = 1'b1;
   endtask

   task automatic test_steady_stream();
      idle_enable = 1'b0;
      write_csr(sms_pkg::CSR_SOFT_MIN, -32'sd40);
      write_csr(sms_pkg::CSR_SOFT_MAX, 32'sd40);
      write_csr(sms_pkg::CSR_STEP_INTERVAL, 32'd250);
      run_random(140);
   endtask

   initial begin : rsp_drain
      int stall;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall = int'($urandom_range(1, 14));
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      sms_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (axis_status_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %0h", $time, rsp_data);
            fail_count++;
         end else begin
            want = axis_status_q.pop_front();
            check_field("step_pulse", 32'(want.step_pulse), 32'(rsp_data.step_pulse));
            check_field("step_direction", 32'(want.step_direction),
                        32'(rsp_data.step_direction));
            check_field("coils_on", 32'(want.coils_on), 32'(rsp_data.coils_on));
            check_field("timer_armed", 32'(want.timer_armed), 32'(rsp_data.timer_armed));
            check_field("next_delay_us", 32'(want.next_delay_us),
                        32'(rsp_data.next_delay_us));
            check_field("position", want.position, rsp_data.position);
            check_field("homed", 32'(want.homed), 32'(rsp_data.homed));
            check_field("busy_res", 32'(want.busy_res), 32'(rsp_data.busy_res));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, axis_status_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_limit_sweep();
      test_backpressure();
      test_steady_stream();
      req_valid <= 1'b0;
      while (axis_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
